### sv/swtb_pkg.sv
`timescale 1ns / 1ps

package swtb_pkg;

	localparam int CMD_W      = 2;
	localparam int ELAPSED_W  = 24;
	localparam int FRAMES_W   = 16;
	localparam int TIME_W     = 32;
	localparam int SCALE_W    = 16;
	localparam int PERIOD_W   = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int MUL_A_W = 16;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int MAG_W   = 26;
	localparam int MOD_W   = TIME_W + 1;

	localparam logic [PROD_W-1:0] SCALE_DEN  = PROD_W'(4096000);
	localparam logic [PROD_W-1:0] SCALE_HALF = PROD_W'(2048000);
	localparam logic [PROD_W-1:0] FRAME_DEN  = PROD_W'(1000);
	localparam logic [PROD_W-1:0] FRAME_HALF = PROD_W'(500);

	localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSED       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = 2'd3;

	localparam logic signed [SCALE_W-1:0] TIME_SCALE_RESET   = 16'sd4096;
	localparam logic [PERIOD_W-1:0]       FRAME_PERIOD_RESET = 20'd16667;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADVANCE = 2'd0,
		CMD_FRAME   = 2'd1,
		CMD_LOAD    = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t                        cmd;
		logic [ELAPSED_W-1:0]        elapsed_us;
		logic signed [FRAMES_W-1:0]  frame_count;
		logic [TIME_W-1:0]           load_value;
	} in_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]        time_ms;
		logic                     wrapped;
		logic signed [TIME_W-1:0] delta_ms;
	} out_item_t;

endpackage

### sv/scaled_wrapping_time_base.sv
`timescale 1ns / 1ps

// Millisecond time base with scaled advance, frame step and load commands. Each item yields
// one result. A load, an unknown command or a scaled advance while paused goes straight from
// idle to the finish state. A scaled advance or frame step runs a bit-serial multiply and a
// restoring division for the rounded change in milliseconds; with a non-zero wrap limit the
// same divider then reduces the new time modulo the limit. A new item is taken only in the
// idle state, once the result of the last one has been handed to the output register.
module scaled_wrapping_time_base import swtb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item
);

	localparam int ITER_W = $clog2(PROD_W + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_DIV  = 5'b00100,
		S_MOD  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	logic signed [SCALE_W-1:0] time_scale_q;
	logic [TIME_W-1:0]         wrap_limit_q;
	logic                      paused_q;
	logic [PERIOD_W-1:0]       frame_period_q;
	logic [TIME_W-1:0]         time_q;

	logic                      rev_q;
	logic                      apply_q;
	logic                      frame_q;
	logic                      neg_q;
	logic [TIME_W-1:0]         res_time_q;

	logic                      out_valid_q;
	out_item_t                 out_item_q;

	logic                      in_fire;
	logic                      fin_fire;
	logic                      needs_mul;
	logic                      limit_nz;
	logic [FRAMES_W-1:0]       fc_bits;
	logic [MUL_A_W-1:0]        fc_abs;
	logic [SCALE_W-1:0]        sc_bits;
	logic [MUL_A_W-1:0]        sc_abs;

	logic                      mul_start;
	logic                      mul_done;
	logic                      div_start;
	logic                      div_done;
	logic [MUL_A_W-1:0]        mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic [PROD_W-1:0]         mul_prod;
	logic [PROD_W-1:0]         div_num;
	logic [TIME_W-1:0]         div_den;
	logic [ITER_W-1:0]         div_iters;
	logic [PROD_W-1:0]         div_quo;
	logic [TIME_W-1:0]         div_rem;

	logic [MOD_W-1:0]          mag33;
	logic [MOD_W-1:0]          prev33;
	logic [MOD_W-1:0]          fwd33;
	logic [MOD_W-1:0]          back33;
	logic [MOD_W-1:0]          mod_in;
	logic                      under;
	logic [TIME_W-1:0]         direct_time;
	logic [TIME_W-1:0]         mod_time;

	logic                      wr;
	logic [TIME_W-1:0]         delta_base;
	logic [TIME_W-1:0]         delta_adj;
	logic [TIME_W-1:0]         delta;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign fin_fire = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign limit_nz = (wrap_limit_q != '0);

	assign fc_bits = in_item.frame_count;
	assign sc_bits = time_scale_q;
	assign fc_abs  = fc_bits[FRAMES_W-1] ? (~fc_bits + MUL_A_W'(1)) : fc_bits;
	assign sc_abs  = sc_bits[SCALE_W-1] ? (~sc_bits + MUL_A_W'(1)) : sc_bits;

	assign needs_mul = (in_item.cmd == CMD_FRAME) || ((in_item.cmd == CMD_ADVANCE) && !paused_q);
	assign mul_a     = (in_item.cmd == CMD_FRAME) ? fc_abs : sc_abs;
	assign mul_b     = (in_item.cmd == CMD_FRAME) ? MUL_B_W'(frame_period_q) : in_item.elapsed_us;
	assign mul_start = in_fire && needs_mul;

	assign mag33  = MOD_W'(div_quo[MAG_W-1:0]);
	assign prev33 = {1'b0, time_q};
	assign fwd33  = prev33 + mag33;
	assign back33 = prev33 - mag33;
	assign under  = rev_q && back33[MOD_W-1];
	assign mod_in = under ? (MOD_W'(0) - back33) : (rev_q ? back33 : fwd33);
	assign direct_time = rev_q ? (under ? '0 : back33[TIME_W-1:0]) : fwd33[TIME_W-1:0];
	assign mod_time = (neg_q && (div_rem != '0)) ? (wrap_limit_q - div_rem) : div_rem;

	always_comb begin
		div_start = 1'b0;
		div_num   = mul_prod + (frame_q ? FRAME_HALF : SCALE_HALF);
		div_den   = frame_q ? TIME_W'(FRAME_DEN) : TIME_W'(SCALE_DEN);
		div_iters = ITER_W'(PROD_W);
		if (state_q == S_MUL && mul_done) begin
			div_start = 1'b1;
		end else if (state_q == S_DIV && div_done && limit_nz) begin
			div_start = 1'b1;
			div_num   = {mod_in, {(PROD_W - MOD_W){1'b0}}};
			div_den   = wrap_limit_q;
			div_iters = ITER_W'(MOD_W);
		end
	end

	swtb_serial_mul #(
		.A_W(MUL_A_W),
		.B_W(MUL_B_W)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	swtb_serial_div #(
		.N_W(PROD_W),
		.D_W(TIME_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.iters (div_iters),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	// Wrap flag and delta are formed from the new time against the time before the item.
	assign wr = apply_q && limit_nz &&
		((!rev_q && (res_time_q < time_q)) || (rev_q && (res_time_q > time_q)));
	assign delta_base = res_time_q - time_q;
	assign delta_adj  = wr ? (rev_q ? (TIME_W'(0) - wrap_limit_q) : wrap_limit_q) : '0;
	assign delta      = (paused_q || !apply_q) ? '0 : (delta_base + delta_adj);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			time_scale_q   <= TIME_SCALE_RESET;
			wrap_limit_q   <= '0;
			paused_q       <= 1'b0;
			frame_period_q <= FRAME_PERIOD_RESET;
			time_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIME_SCALE:   time_scale_q   <= cfg_data[SCALE_W-1:0];
					REG_WRAP_LIMIT:   wrap_limit_q   <= cfg_data[TIME_W-1:0];
					REG_PAUSED:       paused_q       <= cfg_data[0];
					REG_FRAME_PERIOD: frame_period_q <= cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && !fin_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= needs_mul ? S_MUL : S_FIN;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= limit_nz ? S_MOD : S_FIN;
					end
				end
				S_MOD: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						state_q     <= S_IDLE;
						time_q      <= res_time_q;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			apply_q    <= needs_mul;
			frame_q    <= (in_item.cmd == CMD_FRAME);
			rev_q      <= (in_item.cmd == CMD_FRAME) ?
				(fc_bits[FRAMES_W-1] && (frame_period_q != '0)) : sc_bits[SCALE_W-1];
			res_time_q <= (in_item.cmd == CMD_LOAD) ? in_item.load_value : time_q;
		end
		if (state_q == S_DIV && div_done) begin
			neg_q <= under;
			if (!limit_nz) begin
				res_time_q <= direct_time;
			end
		end
		if (state_q == S_MOD && div_done) begin
			res_time_q <= mod_time;
		end
		if (fin_fire) begin
			out_item_q.time_ms  <= res_time_q;
			out_item_q.wrapped  <= wr;
			out_item_q.delta_ms <= delta;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != S_IDLE))
		else $error("block stayed idle after taking an item");

	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL))
		else $error("multiplier finished outside the multiply phase");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == S_DIV) || (state_q == S_MOD)))
		else $error("divider finished outside a divide phase");

	a_time_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && apply_q && limit_nz) |=> (time_q < wrap_limit_q))
		else $error("wrapped time is not below the wrap limit");

	a_no_wrap_without_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && !limit_nz) |=> !out_item_q.wrapped)
		else $error("wrap flag set with no wrap limit");

	a_paused_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && paused_q) |=> (out_item_q.delta_ms == '0))
		else $error("non-zero delta while paused");

endmodule

### sv/swtb_serial_mul.sv
`timescale 1ns / 1ps

module swtb_serial_mul import swtb_pkg::*; #(
	parameter int A_W = MUL_A_W,
	parameter int B_W = MUL_B_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [A_W-1:0]   a,
	input  logic [B_W-1:0]   b,
	output logic             done,
	output logic [A_W+B_W-1:0] prod
);

	localparam int CNT_W = (A_W > 1) ? $clog2(A_W) : 1;

	logic [A_W+B_W-1:0] p_q;
	logic [B_W-1:0]     b_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [B_W:0]       sum;

	assign sum = {1'b0, p_q[A_W+B_W-1:A_W]} + (p_q[0] ? {1'b0, b_q} : {(B_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(A_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{B_W{1'b0}}, a};
			b_q <= b;
		end else if (busy_q) begin
			p_q <= {sum, p_q[A_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

### sv/swtb_serial_div.sv
`timescale 1ns / 1ps

module swtb_serial_div import swtb_pkg::*; #(
	parameter int N_W = PROD_W,
	parameter int D_W = TIME_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [N_W-1:0]              num,
	input  logic [D_W-1:0]              den,
	input  logic [$clog2(N_W+1)-1:0]    iters,
	output logic                        done,
	output logic [N_W-1:0]              quo,
	output logic [D_W-1:0]              rem
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     shifted;
	logic [D_W+1:0]   diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[N_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = !diff[D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import swtb_pkg::*;

	localparam cmd_t CMD_UNUSED = cmd_t'(2'd3);
	localparam int CYCLE_LIMIT = 1500000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;

	logic signed [SCALE_W-1:0] tb_scale = TIME_SCALE_RESET;
	logic [TIME_W-1:0]         tb_limit = '0;
	logic                      tb_paused = 1'b0;
	logic [PERIOD_W-1:0]       tb_period = FRAME_PERIOD_RESET;
	logic [TIME_W-1:0]         tb_time = '0;

	out_item_t expected_times[$];
	int        n_errors = 0;
	int        n_cycles = 0;
	bit        full_rate = 1'b0;

	scaled_wrapping_time_base i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", n_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= full_rate ? 1'b1 : ($urandom_range(99) >= 21);
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		n_errors++;
	endtask

	// Works out the result of one item and moves the time of the model on.
	function automatic out_item_t time_step_model(input in_item_t item);
		out_item_t res;
		logic [TIME_W-1:0] prev;
		longint mag;
		longint mult;
		longint v;
		longint rem;
		logic reverse;
		logic moves;
		res = '0;
		prev = tb_time;
		mag = 0;
		reverse = 1'b0;
		moves = 1'b0;
		case (item.cmd)
			CMD_ADVANCE: begin
				if (!tb_paused) begin
					reverse = tb_scale < 0;
					mult = reverse ? -longint'(tb_scale) : longint'(tb_scale);
					mag = (mult * longint'(item.elapsed_us) + 2048000) / 4096000;
					moves = 1'b1;
				end
			end
			CMD_FRAME: begin
				reverse = item.frame_count < 0 && tb_period != '0;
				mult = item.frame_count < 0 ? -longint'(item.frame_count)
					: longint'(item.frame_count);
				mag = (mult * longint'(tb_period) + 500) / 1000;
				moves = 1'b1;
			end
			CMD_LOAD: begin
				tb_time = item.load_value;
			end
			default: begin
			end
		endcase
		if (moves) begin
			if (tb_limit != '0) begin
				v = longint'(prev) + (reverse ? -mag : mag);
				rem = v % longint'(tb_limit);
				if (rem < 0)
					rem += longint'(tb_limit);
				tb_time = rem[TIME_W-1:0];
				if (!reverse && tb_time < prev) begin
					res.wrapped = 1'b1;
					res.delta_ms = tb_time + tb_limit - prev;
				end else if (reverse && tb_time > prev) begin
					res.wrapped = 1'b1;
					res.delta_ms = tb_time - prev - tb_limit;
				end else begin
					res.delta_ms = tb_time - prev;
				end
			end else begin
				if (reverse)
					tb_time = (mag > prev) ? '0 : prev - mag[TIME_W-1:0];
				else
					tb_time = prev + mag[TIME_W-1:0];
				res.delta_ms = tb_time - prev;
			end
		end
		if (tb_paused)
			res.delta_ms = '0;
		res.time_ms = tb_time;
		return res;
	endfunction

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_times.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, time_ms %0d",
					out_item.time_ms));
			end else begin
				want = expected_times.pop_front();
				if (out_item.time_ms !== want.time_ms)
					report_mismatch($sformatf("time_ms %0d, expected %0d",
						out_item.time_ms, want.time_ms));
				if (out_item.wrapped !== want.wrapped)
					report_mismatch($sformatf("wrapped %0b, expected %0b (time_ms %0d)",
						out_item.wrapped, want.wrapped, want.time_ms));
				if (out_item.delta_ms !== want.delta_ms)
					report_mismatch($sformatf("delta_ms %0d, expected %0d (time_ms %0d)",
						out_item.delta_ms, want.delta_ms, want.time_ms));
			end
		end
	end

	task automatic send_item(input in_item_t item);
		out_item_t want;
		want = time_step_model(item);
		if (!full_rate && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_item <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_times.push_back(want);
	endtask

	task automatic send_cmd(input cmd_t cmd, input logic [ELAPSED_W-1:0] elapsed,
			input logic signed [FRAMES_W-1:0] frames, input logic [TIME_W-1:0] load);
		in_item_t item;
		item.cmd = cmd;
		item.elapsed_us = elapsed;
		item.frame_count = frames;
		item.load_value = load;
		send_item(item);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_times.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic configure(input logic signed [SCALE_W-1:0] scale,
			input logic [TIME_W-1:0] limit, input logic pause,
			input logic [PERIOD_W-1:0] period);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_TIME_SCALE;
		cfg_data <= CFG_DATA_W'(scale);
		@(posedge clk);
		cfg_index <= REG_WRAP_LIMIT;
		cfg_data <= CFG_DATA_W'(limit);
		@(posedge clk);
		cfg_index <= REG_PAUSED;
		cfg_data <= CFG_DATA_W'(pause);
		@(posedge clk);
		cfg_index <= REG_FRAME_PERIOD;
		cfg_data <= CFG_DATA_W'(period);
		@(posedge clk);
		cfg_we <= 1'b0;
		tb_scale = scale;
		tb_limit = limit;
		tb_paused = pause;
		tb_period = period;
	endtask

	// Rounding of the scaled advance and the free-running wrap at the top of the range.
	task automatic test_reset_defaults();
		send_cmd(CMD_ADVANCE, 24'd0, 16'sd0, 32'd0);
		send_cmd(CMD_ADVANCE, 24'd499, 16'sd0, 32'd0);
		send_cmd(CMD_ADVANCE, 24'd500, 16'sd0, 32'd0);
		send_cmd(CMD_ADVANCE, 24'hFFFFFF, -16'sd1, 32'hFFFFFFFF);
		send_cmd(CMD_UNUSED, 24'hFFFFFF, -16'sd1, 32'hFFFFFFFF);
		send_cmd(CMD_LOAD, 24'd0, 16'sd0, 32'hFFFFFFFF);
		send_cmd(CMD_ADVANCE, 24'd2000, 16'sd0, 32'd0);
	endtask

	// Frame steps at the count extremes, and a reverse step that clamps at zero.
	task automatic test_frame_steps();
		configure(TIME_SCALE_RESET, '0, 1'b0, FRAME_PERIOD_RESET);
		send_cmd(CMD_FRAME, 24'd0, 16'sd1, 32'd0);
		send_cmd(CMD_FRAME, 24'd0, -16'sd1, 32'd0);
		send_cmd(CMD_FRAME, 24'd0, 16'sh7FFF, 32'd0);
		send_cmd(CMD_FRAME, 24'd0, 16'sh8000, 32'd0);
		send_cmd(CMD_LOAD, 24'd0, 16'sd0, 32'd5);
		send_cmd(CMD_FRAME, 24'd0, -16'sd1, 32'd0);
	endtask

	// Reverse and forward wraps, a zero frame period and a time loaded above the limit.
	task automatic test_wrap_limit();
		configure(16'sh8000, 32'd1000, 1'b0, '0);
		send_cmd(CMD_FRAME, 24'd0, -16'sd5, 32'd0);
		send_cmd(CMD_ADVANCE, 24'd1000000, 16'sd0, 32'd0);
		send_cmd(CMD_ADVANCE, 24'd100, 16'sd0, 32'd0);
		send_cmd(CMD_LOAD, 24'd0, 16'sd0, 32'd5000);
		send_cmd(CMD_FRAME, 24'd0, 16'sd0, 32'd0);
		configure(16'sh7FFF, 32'hFFFFFFFF, 1'b0, 20'hFFFFF);
		send_cmd(CMD_LOAD, 24'd0, 16'sd0, 32'hFFFFFFFE);
		send_cmd(CMD_FRAME, 24'd0, 16'sd1, 32'd0);
	endtask

	// While paused the scaled advance freezes, frames still move, and delta reads zero.
	task automatic test_paused();
		configure(16'sh7FFF, 32'hFFFFFFFF, 1'b1, 20'hFFFFF);
		send_cmd(CMD_ADVANCE, 24'hFFFFFF, 16'sd0, 32'd0);
		send_cmd(CMD_FRAME, 24'd0, 16'sd3, 32'd0);
		send_cmd(CMD_LOAD, 24'd0, 16'sd0, 32'd7);
		send_cmd(CMD_UNUSED, 24'd0, 16'sd0, 32'd0);
		configure(16'sd0, 32'd1, 1'b0, 20'd1000000);
		send_cmd(CMD_ADVANCE, 24'hFFFFFF, 16'sd0, 32'd0);
		send_cmd(CMD_FRAME, 24'd0, 16'sh8000, 32'd0);
	endtask

	task automatic test_random_traffic();
		in_item_t item;
		logic signed [SCALE_W-1:0] scale;
		logic [TIME_W-1:0] limit;
		logic [PERIOD_W-1:0] period;
		int pick;
		for (int phase = 0; phase < 12; phase++) begin
			case ($urandom_range(5))
				0: scale = 16'sh8000;
				1: scale = 16'sh7FFF;
				2: scale = 16'sd0;
				3: scale = TIME_SCALE_RESET;
				4: scale = -16'sd4096;
				default: scale = SCALE_W'($urandom);
			endcase
			case ($urandom_range(4))
				0: limit = '0;
				1: limit = $urandom_range(1, 50);
				2: limit = $urandom_range(1, 5000);
				3: limit = 32'hFFFFFFFF;
				default: limit = $urandom;
			endcase
			case ($urandom_range(4))
				0: period = '0;
				1: period = FRAME_PERIOD_RESET;
				2: period = 20'hFFFFF;
				3: period = 20'd1000000;
				default: period = PERIOD_W'($urandom);
			endcase
			configure(scale, limit, $urandom_range(5) == 0, period);
			full_rate = (phase == 6);
			repeat (100) begin
				pick = $urandom_range(99);
				if (pick < 45)
					item.cmd = CMD_ADVANCE;
				else if (pick < 85)
					item.cmd = CMD_FRAME;
				else if (pick < 95)
					item.cmd = CMD_LOAD;
				else
					item.cmd = CMD_UNUSED;
				item.elapsed_us = $urandom_range(1) ? ELAPSED_W'($urandom_range(100000))
					: ELAPSED_W'($urandom);
				if ($urandom_range(99) < 60)
					item.frame_count = FRAMES_W'(int'($urandom_range(400)) - 200);
				else
					item.frame_count = FRAMES_W'($urandom);
				case ($urandom_range(2))
					0: item.load_value = (tb_limit != '0) ? $urandom_range(tb_limit - 1, 0)
						: $urandom;
					1: item.load_value = 32'hFFFFFFFF - $urandom_range(20000);
					default: item.load_value = $urandom;
				endcase
				send_item(item);
			end
		end
		full_rate = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_frame_steps();
		test_wrap_limit();
		test_paused();
		test_random_traffic();
		wait_idle();
		repeat (200) @(posedge clk);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
